// ===== src/rmq_pkg.sv =====
package rmq_pkg;

    // Word and numerator widths fixed by the Q2.14 interface.
    localparam int DATA_W        = 16;
    localparam int NUM_W         = 17;
    localparam int FRAC_BITS_DEF = 14;

    // Index of the largest diagonal element.
    localparam logic [1:0] IDX_X = 2'd0;
    localparam logic [1:0] IDX_Y = 2'd1;
    localparam logic [1:0] IDX_Z = 2'd2;

    // Path information that travels with each word.
    typedef struct packed {
        logic       trace;
        logic [1:0] idx;
        logic       degen;
    } t_ctl;

endpackage

// ===== src/rotation_matrix_to_quaternion.sv =====
// Channel  Direction  Handshake            Payload
// matrix   in         i_valid / o_ready    i_m00 .. i_m22, 16 bit signed each
// quat     out        o_valid / i_ready    o_qw o_qx o_qy o_qz, o_degenerate
//
// One word enters per cycle while the output is not stalled. SQW is the
// number of root bits (17 at the default of 14 fraction bits). The stages:
// one setup stage, one square root stage per root bit, one divider setup
// stage, seventeen restoring divider stages and the output register.
// Reset clears only the valid bits. A stall freezes every stage at once.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m00,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m01,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m02,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m10,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m11,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m12,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m20,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m21,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m22,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [rmq_pkg::DATA_W-1:0]  o_qw,
    output logic signed [rmq_pkg::DATA_W-1:0]  o_qx,
    output logic signed [rmq_pkg::DATA_W-1:0]  o_qy,
    output logic signed [rmq_pkg::DATA_W-1:0]  o_qz,
    output logic                               o_degenerate
);
    import rmq_pkg::*;

    // Radicand bits, scaled radicand bits, root bits and remainder bits.
    localparam int RW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int VW0  = RW + FRAC_BITS;
    localparam int VW   = VW0 + (VW0 % 2);
    localparam int SQW  = VW / 2;
    localparam int RMW  = SQW + 2;
    localparam int DVW  = ((FRAC_BITS > SQW) ? FRAC_BITS : SQW) + 18;
    localparam int QB   = 16;

    localparam logic signed [RW:0] FX_ONE =
        {{(RW-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    logic en;

    // The whole pipe advances when the output register is free or taken.
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // ------------------------------------------------------------------
    // Setup stage: trace, path choice, radicand and numerators.
    // ------------------------------------------------------------------
    logic signed [17:0]      trace;
    logic                    trace_pos;
    logic [1:0]              idx;
    logic signed [DATA_W-1:0] dii, djj, dkk;
    logic signed [RW:0]      rad;
    logic                    degen;
    logic signed [NUM_W-1:0] num_a, num_b, num_c;

    always_comb begin
        trace     = 18'(i_m00) + 18'(i_m11) + 18'(i_m22);
        trace_pos = trace > 18'sd0;
        idx = IDX_X;
        if (i_m11 > i_m00) begin
            idx = IDX_Y;
        end
        if (i_m22 > ((idx == IDX_Y) ? i_m11 : i_m00)) begin
            idx = IDX_Z;
        end
        unique case (idx)
            IDX_Y: begin
                dii = i_m11; djj = i_m22; dkk = i_m00;
            end
            IDX_Z: begin
                dii = i_m22; djj = i_m00; dkk = i_m11;
            end
            default: begin
                dii = i_m00; djj = i_m11; dkk = i_m22;
            end
        endcase
        if (trace_pos) begin
            rad   = (RW+1)'(trace) + FX_ONE;
            num_a = NUM_W'(i_m12) - NUM_W'(i_m21);
            num_b = NUM_W'(i_m20) - NUM_W'(i_m02);
            num_c = NUM_W'(i_m01) - NUM_W'(i_m10);
        end else begin
            rad = (RW+1)'(dii) - (RW+1)'(djj) - (RW+1)'(dkk) + FX_ONE;
            unique case (idx)
                IDX_Y: begin
                    num_a = NUM_W'(i_m20) - NUM_W'(i_m02);
                    num_b = NUM_W'(i_m12) + NUM_W'(i_m21);
                    num_c = NUM_W'(i_m10) + NUM_W'(i_m01);
                end
                IDX_Z: begin
                    num_a = NUM_W'(i_m01) - NUM_W'(i_m10);
                    num_b = NUM_W'(i_m20) + NUM_W'(i_m02);
                    num_c = NUM_W'(i_m21) + NUM_W'(i_m12);
                end
                default: begin
                    num_a = NUM_W'(i_m12) - NUM_W'(i_m21);
                    num_b = NUM_W'(i_m01) + NUM_W'(i_m10);
                    num_c = NUM_W'(i_m02) + NUM_W'(i_m20);
                end
            endcase
        end
        degen = !trace_pos && (rad <= '0);
    end

    // Square root pipe, one root bit per stage.
    logic                    r_sq_valid [0:SQW];
    t_ctl                    r_sq_ctl   [0:SQW];
    logic signed [NUM_W-1:0] r_sq_num   [0:SQW][0:2];
    logic [SQW-1:0]          r_sq_root  [0:SQW];
    logic [VW-1:0]           r_sq_v     [0:SQW-1];
    logic [RMW-1:0]          r_sq_rem   [0:SQW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid[0] <= 1'b0;
        end else if (en) begin
            r_sq_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_ctl[0]    <= '{trace: trace_pos, idx: idx, degen: degen};
            r_sq_num[0][0] <= num_a;
            r_sq_num[0][1] <= num_b;
            r_sq_num[0][2] <= num_c;
            r_sq_root[0]   <= '0;
            r_sq_rem[0]    <= '0;
            r_sq_v[0]      <= degen ? '0 : VW'({rad[RW-1:0], {FRAC_BITS{1'b0}}});
        end
    end

    for (genvar g = 0; g < SQW; g++) begin : g_sqrt
        logic [RMW-1:0] rem2;
        logic [RMW-1:0] trial;
        logic           take;

        always_comb begin
            rem2  = {r_sq_rem[g][RMW-3:0], r_sq_v[g][VW-1 -: 2]};
            trial = {r_sq_root[g], 2'b01};
            take  = rem2 >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[g+1] <= 1'b0;
            end else if (en) begin
                r_sq_valid[g+1] <= r_sq_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_ctl[g+1]  <= r_sq_ctl[g];
                r_sq_num[g+1]  <= r_sq_num[g];
                r_sq_root[g+1] <= {r_sq_root[g][SQW-2:0], take};
            end
        end

        if (g < SQW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq_v[g+1]   <= r_sq_v[g] << 2;
                    r_sq_rem[g+1] <= take ? (rem2 - trial) : rem2;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider setup: divisor 2s, half root, rounded dividends.
    // ------------------------------------------------------------------
    logic [SQW-1:0] root;
    logic [SQW:0]   half_sum;

    assign root     = r_sq_root[SQW];
    assign half_sum = {1'b0, root} + (SQW+1)'(1);

    logic           r_pd_valid;
    t_ctl           r_pd_ctl;
    logic [SQW:0]   r_pd_d;
    logic [SQW-1:0] r_pd_half;
    logic [DVW-1:0] r_pd_rem [0:2];
    logic           r_pd_neg [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pd_valid <= 1'b0;
        end else if (en) begin
            r_pd_valid <= r_sq_valid[SQW];
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_prep
        logic             neg;
        logic [NUM_W-1:0] mag;

        always_comb begin
            neg = r_sq_num[SQW][l] < 0;
            mag = neg ? NUM_W'(-r_sq_num[SQW][l]) : NUM_W'(r_sq_num[SQW][l]);
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pd_neg[l] <= neg;
                r_pd_rem[l] <= DVW'({mag, {FRAC_BITS{1'b0}}}) + DVW'(root);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pd_ctl  <= r_sq_ctl[SQW];
            r_pd_d    <= {root, 1'b0};
            r_pd_half <= half_sum[SQW:1];
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider: overflow check, then one quotient bit a stage.
    // ------------------------------------------------------------------
    logic           r_dv_valid [0:QB];
    t_ctl           r_dv_ctl   [0:QB];
    logic [SQW-1:0] r_dv_half  [0:QB];
    logic           r_dv_neg   [0:QB][0:2];
    logic           r_dv_ovf   [0:QB][0:2];
    logic [SQW:0]   r_dv_d     [0:QB-1];
    logic [DVW-1:0] r_dv_rem   [0:QB-1][0:2];
    logic [QB-1:0]  r_dv_q     [1:QB][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (en) begin
            r_dv_valid[0] <= r_pd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_ctl[0]  <= r_pd_ctl;
            r_dv_half[0] <= r_pd_half;
            r_dv_d[0]    <= r_pd_d;
            for (int l = 0; l < 3; l++) begin
                r_dv_neg[0][l] <= r_pd_neg[l];
                r_dv_rem[0][l] <= r_pd_rem[l];
                r_dv_ovf[0][l] <= r_pd_rem[l] >= (DVW'(r_pd_d) << QB);
            end
        end
    end

    for (genvar g = 1; g <= QB; g++) begin : g_div
        logic [DVW-1:0] dsh;
        logic           take [0:2];

        always_comb begin
            dsh = DVW'(r_dv_d[g-1]) << (QB - g);
            for (int l = 0; l < 3; l++) begin
                take[l] = r_dv_rem[g-1][l] >= dsh;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[g] <= 1'b0;
            end else if (en) begin
                r_dv_valid[g] <= r_dv_valid[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_ctl[g]  <= r_dv_ctl[g-1];
                r_dv_half[g] <= r_dv_half[g-1];
                r_dv_neg[g]  <= r_dv_neg[g-1];
                r_dv_ovf[g]  <= r_dv_ovf[g-1];
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            if (g == 1) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_dv_q[g][l] <= QB'(take[l]);
                    end
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_dv_q[g][l] <= {r_dv_q[g-1][l][QB-2:0], take[l]};
                    end
                end
            end
        end

        if (g < QB) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_d[g] <= r_dv_d[g-1];
                    for (int l = 0; l < 3; l++) begin
                        r_dv_rem[g][l] <= take[l] ? (r_dv_rem[g-1][l] - dsh)
                                                  : r_dv_rem[g-1][l];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: saturate, sign and route the lanes.
    // ------------------------------------------------------------------
    function automatic logic signed [DATA_W-1:0] f_sat(
        input logic          ovf,
        input logic [QB-1:0] q,
        input logic          neg
    );
        logic [QB:0] m;
        logic signed [DATA_W-1:0] res;
        begin
            m = ovf ? '1 : {1'b0, q};
            if (neg) begin
                res = (m > 17'd32768) ? 16'sh8000 : DATA_W'(-m);
            end else begin
                res = (m > 17'd32767) ? 16'sh7FFF : m[DATA_W-1:0];
            end
            return res;
        end
    endfunction

    logic [31:0]              half_ext;
    logic signed [DATA_W-1:0] lane_h, lane_a, lane_b, lane_c;
    logic signed [DATA_W-1:0] n_qw, n_qx, n_qy, n_qz;
    t_ctl                     ctl_out;

    always_comb begin
        ctl_out  = r_dv_ctl[QB];
        half_ext = 32'(r_dv_half[QB]);
        lane_h   = (half_ext > 32'd32767) ? 16'sh7FFF : half_ext[DATA_W-1:0];
        lane_a   = f_sat(r_dv_ovf[QB][0], r_dv_q[QB][0], r_dv_neg[QB][0]);
        lane_b   = f_sat(r_dv_ovf[QB][1], r_dv_q[QB][1], r_dv_neg[QB][1]);
        lane_c   = f_sat(r_dv_ovf[QB][2], r_dv_q[QB][2], r_dv_neg[QB][2]);
        priority if (ctl_out.degen) begin
            n_qw = '0; n_qx = '0; n_qy = '0; n_qz = '0;
        end else if (ctl_out.trace) begin
            n_qw = lane_h; n_qx = lane_a; n_qy = lane_b; n_qz = lane_c;
        end else begin
            n_qw = lane_a;
            unique case (ctl_out.idx)
                IDX_Y: begin
                    n_qy = lane_h; n_qz = lane_b; n_qx = lane_c;
                end
                IDX_Z: begin
                    n_qz = lane_h; n_qx = lane_b; n_qy = lane_c;
                end
                default: begin
                    n_qx = lane_h; n_qy = lane_b; n_qz = lane_c;
                end
            endcase
        end
    end

    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv_valid[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_qw         <= n_qw;
            o_qx         <= n_qx;
            o_qy         <= n_qy;
            o_qz         <= n_qz;
            o_degenerate <= ctl_out.degen;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== test/tb_rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps

// Scoreboard for quaternion words: holds the predicted quaternion of every
// accepted matrix and compares each delivered word against the oldest one.
class quat_scoreboard;
    typedef struct {
        logic signed [15:0] qw, qx, qy, qz;
        logic               degen;
    } quat_t;

    quat_t pending[$];
    int    mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Integer square root, floor.
    static function longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Quotient num * 2^14 / (2s), rounded to nearest, ties away from zero.
    static function longint ratio(longint num, longint s);
        longint unsigned d, mag, q;
        d = s * 2;
        mag = (num < 0) ? -num : num;
        mag = mag << rmq_pkg::FRAC_BITS_DEF;
        q = (mag + d / 2) / d;
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    static function logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    // Note one accepted matrix and store its predicted quaternion.
    function void note_matrix(logic signed [15:0] m[9]);
        longint a[3][3];
        longint q[4];
        longint tr, rad, s;
        int i, j, k;
        quat_t e;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) a[r][c] = m[r*3+c];
        q = '{0, 0, 0, 0};
        e.degen = 0;
        tr = a[0][0] + a[1][1] + a[2][2];
        if (tr > 0) begin
            rad = tr + (64'd1 << rmq_pkg::FRAC_BITS_DEF);
            s = root_floor(rad << rmq_pkg::FRAC_BITS_DEF);
            q[3] = (s + 1) >>> 1;
            q[0] = ratio(a[1][2] - a[2][1], s);
            q[1] = ratio(a[2][0] - a[0][2], s);
            q[2] = ratio(a[0][1] - a[1][0], s);
        end else begin
            i = rmq_pkg::IDX_X;
            if (a[1][1] > a[0][0]) i = rmq_pkg::IDX_Y;
            if (a[2][2] > a[i][i]) i = rmq_pkg::IDX_Z;
            j = (i == 2) ? 0 : i + 1;
            k = (j == 2) ? 0 : j + 1;
            rad = a[i][i] - (a[j][j] + a[k][k]) + (64'd1 << rmq_pkg::FRAC_BITS_DEF);
            if (rad <= 0) begin
                e.degen = 1;
            end else begin
                s = root_floor(rad << rmq_pkg::FRAC_BITS_DEF);
                q[i] = (s + 1) >>> 1;
                q[3] = ratio(a[j][k] - a[k][j], s);
                q[j] = ratio(a[i][j] + a[j][i], s);
                q[k] = ratio(a[i][k] + a[k][i], s);
            end
        end
        e.qw = clamp16(q[3]);
        e.qx = clamp16(q[0]);
        e.qy = clamp16(q[1]);
        e.qz = clamp16(q[2]);
        pending.push_back(e);
    endfunction

    // Compare one delivered word with the oldest prediction.
    function void check_quat(quat_t got);
        quat_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected word qw=%0d qx=%0d qy=%0d qz=%0d degen=%0b",
                         got.qw, got.qx, got.qy, got.qz, got.degen);
            return;
        end
        e = pending.pop_front();
        if (got.qw !== e.qw || got.qx !== e.qx || got.qy !== e.qy ||
            got.qz !== e.qz || got.degen !== e.degen) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Expected %0d %0d %0d %0d %0b, got %0d %0d %0d %0d %0b",
                         e.qw, e.qx, e.qy, e.qz, e.degen,
                         got.qw, got.qx, got.qy, got.qz, got.degen);
        end
    endfunction
endclass

module tb_rotation_matrix_to_quaternion;
    import rmq_pkg::*;

    localparam int  LATENCY = 37;
    localparam int  RANDOM_WORDS = 1800;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready, o_degenerate;
    logic signed [DATA_W-1:0] i_m00, i_m01, i_m02, i_m10, i_m11, i_m12;
    logic signed [DATA_W-1:0] i_m20, i_m21, i_m22;
    logic signed [DATA_W-1:0] o_qw, o_qx, o_qy, o_qz;

    quat_scoreboard board;
    longint cycles;
    bit     quiet_tail;
    int     sent;

    rotation_matrix_to_quaternion DUT (.*);

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Accept results at the rising edge and check them.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready)
            board.check_quat('{o_qw, o_qx, o_qy, o_qz, o_degenerate});
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver stalls in bursts; none in the last part of the run.
    initial begin
        int n;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 10);
                i_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end
    end

    // Present one matrix and hold it until it is accepted.
    task automatic send_matrix(logic signed [15:0] m[9]);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        {i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22} <=
            {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        board.note_matrix(m);
        sent++;
        @(negedge i_clk);
    endtask

    // A rotation-like matrix: non-negative diagonal on a chosen axis, non-positive elsewhere, or all random.
    function automatic void make_rotation(ref logic signed [15:0] m[9]);
        int ax;
        ax = $urandom_range(0, 3);
        for (int n = 0; n < 9; n++) m[n] = $urandom_range(0, 32767) - 16384;
        if (ax < 3) begin
            for (int d = 0; d < 3; d++)
                m[d*4] = (d == ax) ? $urandom_range(0, 16384)
                                   : -$urandom_range(0, 16384);
        end
    endfunction

    initial begin
        logic signed [15:0] m[9];
        int wait_n;
        board = new();
        cycles = 0;
        sent = 0;
        quiet_tail = 0;
        i_valid = 1'b0;
        {i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22} = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: identity, axis flips, extremes, ties, degenerate.
        m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};        send_matrix(m);
        m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};      send_matrix(m);
        m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};      send_matrix(m);
        m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};      send_matrix(m);
        m = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384};       send_matrix(m);
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                    send_matrix(m);
        m = '{-100, 5, 6, 7, -100, 8, 9, 10, -100};          send_matrix(m);
        m = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767,
              -32768};                                       send_matrix(m);
        m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
              32767};                                        send_matrix(m);
        m = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768,
              32767};                                        send_matrix(m);
        m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768,
              -32768, -32768};                               send_matrix(m);
        m = '{-32768, 32767, 32767, -32768, 32767, 32767, 32767, -32768,
              -32768};                                       send_matrix(m);
        m = '{1, 100, 200, 300, 1, 400, 500, 600, 1};        send_matrix(m);
        m = '{0, 1, 2, 3, 0, 4, 5, 6, -1};                   send_matrix(m);
        m = '{-1, 32767, -32768, -32768, 1, 32767, 32767, -32768, 0};
        send_matrix(m);
        m = '{-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767,
              32767};                                        send_matrix(m);

        // Random words: mostly rotation-shaped, some fully random.
        for (int w = 0; w < RANDOM_WORDS; w++) begin
            if (w > RANDOM_WORDS - 200) quiet_tail = 1;
            if ($urandom_range(0, 3) == 0)
                for (int n = 0; n < 9; n++) m[n] = $urandom();
            else
                make_rotation(m);
            send_matrix(m);
        end
        quiet_tail = 1;
        i_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        wait_n = 0;
        while (wait_n < 2 * LATENCY) begin
            @(posedge i_clk);
            wait_n++;
        end
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== rotation_matrix_to_quaternion.f =====
src/rmq_pkg.sv
src/rotation_matrix_to_quaternion.sv
test/tb_rotation_matrix_to_quaternion.sv
